### rtl/prs_pkg.sv
// Package for the path reliability scorer: widths, constants, state and
// register codes, and the request structs of the serial arithmetic units.
// No dependencies.
package prs_pkg;

  // Default depth of one path
  localparam int unsigned PRS_MAX_SAMPLES = 4096;

  // Serial unit widths
  localparam int unsigned DVD_W  = 64;  // divider dividend / quotient
  localparam int unsigned DSR_W  = 40;  // divider divisor / remainder
  localparam int unsigned DSTP_W = 7;   // divider step count
  localparam int unsigned MCD_W  = 48;  // multiplicand
  localparam int unsigned MPL_W  = 32;  // multiplier
  localparam int unsigned MSTP_W = 6;   // multiplier step count
  localparam int unsigned PROD_W = MCD_W + MPL_W;

  // Field and total widths
  localparam int unsigned RISK_W   = 16;
  localparam int unsigned DIST_W   = 24;
  localparam int unsigned RTOT_W   = 29;
  localparam int unsigned SQTOT_W  = 45;
  localparam int unsigned RCTOT_W  = 45;
  localparam int unsigned E_W      = 50;
  localparam int unsigned SCORE_W  = 17;
  localparam int unsigned ACC_W    = 36;  // series partial sums

  // Constants
  localparam logic [RTOT_W-1:0]  RTOT_MAX  = '1;
  localparam logic [SQTOT_W-1:0] SQTOT_MAX = '1;
  localparam logic [RCTOT_W-1:0] RCTOT_MAX = '1;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 24'h7F_FFFF;
  localparam logic [31:0]        LN2_Q32   = 32'hB172_17F7;
  localparam logic [E_W-1:0]     EXP_LIMIT = E_W'(12) << 24;
  localparam logic [15:0]        EPS_DFLT  = 16'd4;
  localparam logic [3:0]         EXP_TERMS = 4'd12;
  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h1_0000;

  // Step counts of the serial operations with a fixed step count
  localparam logic [DSTP_W-1:0] STP_RECIP = 7'd29;
  localparam logic [DSTP_W-1:0] STP_MEAN  = 7'd29;
  localparam logic [DSTP_W-1:0] STP_CLEAR = 7'd45;
  localparam logic [DSTP_W-1:0] STP_VAR   = 7'd64;
  localparam logic [DSTP_W-1:0] STP_LOG   = 7'd36;
  localparam logic [DSTP_W-1:0] STP_TERM  = 7'd33;
  localparam logic [MSTP_W-1:0] STP_SQ    = 6'd16;
  localparam logic [MSTP_W-1:0] STP_SS    = 6'd29;
  localparam logic [MSTP_W-1:0] STP_WGT   = 6'd16;
  localparam logic [MSTP_W-1:0] STP_TMUL  = 6'd32;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RISK_WEIGHT      = 2'd0,
    REG_CLEARANCE_WEIGHT = 2'd1,
    REG_VARIANCE_WEIGHT  = 2'd2,
    REG_DISTANCE_OFFSET  = 2'd3
  } prs_reg_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_SAMPLE, ST_FIN, ST_MEAN, ST_CLEAR, ST_NQ, ST_S2, ST_NN,
    ST_VAR, ST_EA, ST_EB, ST_EC, ST_LOG, ST_TMUL, ST_TDIV, ST_SCORE, ST_OUT
  } prs_state_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
    logic [DSTP_W-1:0] steps;
  } prs_div_req_t;

  typedef struct packed {
    logic              start;
    logic [MCD_W-1:0]  mcand;
    logic [MPL_W-1:0]  mplier;
    logic [MSTP_W-1:0] steps;
  } prs_mul_req_t;

endpackage

### rtl/path_reliability_scorer.sv
// Path reliability scorer: accumulates per-sample risk statistics of a path
// and scores the path on its last sample.
//
// Channels: in_* carries one sample per transfer (tdata: risk, distance;
// tuser: query_ok; tlast: last sample of the path). out_* carries one result
// per path (tuser: path_valid; tdata: the metrics and the score). cfg_* writes
// the four weight and offset registers by index.
// Timing: a sample with query_ok set and room left in the totals waits for
// the bit-serial divider that forms the reciprocal clearance (29 steps);
// other samples are taken without a divide. After the last sample of a valid
// path with samples, the finishing sequence runs the divider and the shift-add
// multiplier one after the other (means, variance, weighted exponent, a
// 12-term series); the series is skipped when the weighted exponent reaches
// 12. in_tready is high only while the sequencer waits for a sample.
// Reset returns the weights to their defaults and clears the totals; no
// clearing pass is needed. A result waits in the output register while the
// receiver stalls; the next path is accepted meanwhile, and its own result
// waits until that register is free.
module path_reliability_scorer import prs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = PRS_MAX_SAMPLES
) (
  input  logic         clk,
  input  logic         rst_n,
  // Sample stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // [15:0] sample_risk, [39:16] sample_distance
  input  logic         in_tuser,   // [0] query_ok
  input  logic         in_tlast,   // last_sample
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [15:0] mean_risk, [47:16] mean_clearance_risk,
                                   // [79:48] variance, [103:80] min_clearance,
                                   // [120:104] reliability_score, rest zero
  output logic         out_tuser,  // [0] path_valid
  // Configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  prs_state_t state_r, state_nxt;

  logic [15:0] risk_wgt_r, clr_wgt_r, var_wgt_r, dist_ofs_r;

  logic [CNT_W-1:0]   count_r;
  logic [RTOT_W-1:0]  risk_tot_r;
  logic [SQTOT_W-1:0] sq_tot_r;
  logic [RCTOT_W-1:0] rcp_tot_r;
  logic [DIST_W-1:0]  low_r;
  logic               all_valid_r;
  logic [RISK_W-1:0]  smp_risk_r;
  logic [DIST_W-1:0]  smp_dist_r;
  logic               smp_last_r;

  logic               res_ok_r;
  logic [15:0]        mean_r;
  logic [31:0]        clear_r, var_r;
  logic [63:0]        nq_r, s2_r;
  logic [E_W-1:0]     e_r;
  logic [5:0]         n_r;
  logic [31:0]        r_r;
  logic [ACC_W-1:0]   pos_r, neg_r;
  logic [3:0]         k_r;
  logic [SCORE_W-1:0] score_r;

  logic               out_tvalid_r;
  logic [127:0]       out_tdata_r;
  logic               out_tuser_r;

  prs_div_req_t      div_req;
  prs_mul_req_t      mul_req;
  logic              div_done, mul_done;
  logic [DVD_W-1:0]  div_q;
  logic [DSR_W-1:0]  div_rem;
  logic [PROD_W-1:0] mul_prod;

  logic               in_acc;
  logic [RISK_W-1:0]  in_risk;
  logic [DIST_W-1:0]  in_dist;
  logic               take;
  logic [23:0]        den;
  logic [15:0]        eps;
  logic [RTOT_W:0]    risk_add;
  logic [SQTOT_W:0]   sq_sum;
  logic [RCTOT_W:0]   rcp_sum;
  logic [63:0]        var_dvd;
  logic [E_W-1:0]     e_sum;
  logic [32:0]        term;
  logic [ACC_W-1:0]   e_diff, e_shift;
  logic [ACC_W:0]     e_round;
  logic [SCORE_W-1:0] score_val;
  logic               slot_free;

  prs_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  prs_multiplier u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Sample decode and accumulate condition
  assign in_acc  = in_tvalid && in_tready;
  assign in_risk = in_tdata[15:0];
  assign in_dist = in_tdata[39:16];
  assign take    = in_tuser && (count_r < CNT_W'(MAX_SAMPLES));
  assign eps     = (dist_ofs_r == '0) ? EPS_DFLT : dist_ofs_r;
  assign den     = (in_dist[DIST_W-1] ? 24'd0 : {1'b0, in_dist[DIST_W-2:0]}) + 24'(eps);

  // Saturating sums of the running totals
  assign risk_add = {1'b0, risk_tot_r} + (RTOT_W+1)'(smp_risk_r);
  assign sq_sum   = {1'b0, sq_tot_r} + (SQTOT_W+1)'(mul_prod[31:0]);
  assign rcp_sum  = {1'b0, rcp_tot_r} + (RCTOT_W+1)'(div_q[28:0]);

  // Finishing arithmetic
  assign var_dvd   = (nq_r > s2_r) ? nq_r - s2_r : 64'd0;
  assign e_sum     = e_r + mul_prod[E_W-1:0];
  assign term      = div_q[32:0];
  assign e_diff    = (pos_r > neg_r) ? pos_r - neg_r : '0;
  assign e_shift   = e_diff >> n_r;
  assign e_round   = (ACC_W+1)'(e_shift) + (ACC_W+1)'(17'h0_8000);
  assign score_val = (e_round[ACC_W:16] > (ACC_W-15)'(SCORE_ONE)) ? SCORE_ONE
                   : e_round[16 +: SCORE_W];

  assign slot_free = !out_tvalid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = take ? ST_SAMPLE : (in_tlast ? ST_FIN : ST_IDLE);
      ST_SAMPLE: if (div_done) state_nxt = smp_last_r ? ST_FIN : ST_IDLE;
      ST_FIN:    state_nxt = (all_valid_r && count_r != '0) ? ST_MEAN : ST_OUT;
      ST_MEAN:   if (div_done) state_nxt = ST_CLEAR;
      ST_CLEAR:  if (div_done) state_nxt = ST_NQ;
      ST_NQ:     if (mul_done) state_nxt = ST_S2;
      ST_S2:     if (mul_done) state_nxt = ST_NN;
      ST_NN:     if (mul_done) state_nxt = ST_VAR;
      ST_VAR:    if (div_done) state_nxt = ST_EA;
      ST_EA:     if (mul_done) state_nxt = ST_EB;
      ST_EB:     if (mul_done) state_nxt = ST_EC;
      ST_EC:     if (mul_done) state_nxt = (e_sum >= EXP_LIMIT) ? ST_OUT : ST_LOG;
      ST_LOG:    if (div_done) state_nxt = ST_TMUL;
      ST_TMUL:   if (mul_done) state_nxt = ST_TDIV;
      ST_TDIV:   if (div_done) state_nxt = (k_r == EXP_TERMS) ? ST_SCORE : ST_TMUL;
      ST_SCORE:  state_nxt = ST_OUT;
      ST_OUT:    if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Unit requests and handshake outputs
  always_comb begin
    div_req   = '0;
    mul_req   = '0;
    in_tready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && take) begin
          div_req = '{1'b1, 64'h1000_0000, DSR_W'(den), STP_RECIP};
          mul_req = '{1'b1, MCD_W'(in_risk), MPL_W'(in_risk), STP_SQ};
        end
      end
      ST_FIN: begin
        if (all_valid_r && count_r != '0)
          div_req = '{1'b1, DVD_W'(risk_tot_r), DSR_W'(count_r), STP_MEAN};
      end
      ST_MEAN: begin
        if (div_done)
          div_req = '{1'b1, DVD_W'(rcp_tot_r), DSR_W'(count_r), STP_CLEAR};
      end
      ST_CLEAR: begin
        if (div_done)
          mul_req = '{1'b1, MCD_W'(sq_tot_r), MPL_W'(count_r), MSTP_W'(CNT_W)};
      end
      ST_NQ: begin
        if (mul_done)
          mul_req = '{1'b1, MCD_W'(risk_tot_r), MPL_W'(risk_tot_r), STP_SS};
      end
      ST_S2: begin
        if (mul_done)
          mul_req = '{1'b1, MCD_W'(count_r), MPL_W'(count_r), MSTP_W'(CNT_W)};
      end
      ST_NN: begin
        if (mul_done)
          div_req = '{1'b1, var_dvd, mul_prod[DSR_W-1:0], STP_VAR};
      end
      ST_VAR: begin
        if (div_done)
          mul_req = '{1'b1, MCD_W'({mean_r, 8'd0}), MPL_W'(risk_wgt_r), STP_WGT};
      end
      ST_EA: begin
        if (mul_done)
          mul_req = '{1'b1, MCD_W'(clear_r), MPL_W'(clr_wgt_r), STP_WGT};
      end
      ST_EB: begin
        if (mul_done)
          mul_req = '{1'b1, MCD_W'(var_r), MPL_W'(var_wgt_r), STP_WGT};
      end
      ST_EC: begin
        if (mul_done && e_sum < EXP_LIMIT)
          div_req = '{1'b1, DVD_W'({e_sum[27:0], 8'd0}), DSR_W'(LN2_Q32), STP_LOG};
      end
      ST_LOG: begin
        if (div_done)
          mul_req = '{1'b1, MCD_W'(33'h1_0000_0000), div_rem[MPL_W-1:0], STP_TMUL};
      end
      ST_TMUL: begin
        if (mul_done)
          div_req = '{1'b1, DVD_W'(mul_prod[PROD_W-1:32]), DSR_W'(k_r), STP_TERM};
      end
      ST_TDIV: begin
        if (div_done && k_r != EXP_TERMS)
          mul_req = '{1'b1, MCD_W'(term), r_r, STP_TMUL};
      end
      default: begin
      end
    endcase
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      risk_wgt_r <= 16'd256;
      clr_wgt_r  <= 16'd256;
      var_wgt_r  <= 16'd256;
      dist_ofs_r <= EPS_DFLT;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (prs_reg_t'(cfg_index))
          REG_RISK_WEIGHT:      risk_wgt_r <= cfg_data;
          REG_CLEARANCE_WEIGHT: clr_wgt_r  <= cfg_data;
          REG_VARIANCE_WEIGHT:  var_wgt_r  <= cfg_data;
          REG_DISTANCE_OFFSET:  dist_ofs_r <= cfg_data;
        endcase
      end
    end
  end

  assign cfg_ready = 1'b1;

  // Path totals: accumulate valid samples, clear once the result is loaded into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      risk_tot_r  <= '0;
      sq_tot_r    <= '0;
      rcp_tot_r   <= '0;
      low_r       <= DIST_MAX;
      all_valid_r <= 1'b1;
    end else if (state_r == ST_OUT && slot_free) begin
      count_r     <= '0;
      risk_tot_r  <= '0;
      sq_tot_r    <= '0;
      rcp_tot_r   <= '0;
      low_r       <= DIST_MAX;
      all_valid_r <= 1'b1;
    end else if (state_r == ST_IDLE && in_acc && !in_tuser) begin
      all_valid_r <= 1'b0;
    end else if (state_r == ST_SAMPLE && div_done) begin
      count_r    <= count_r + 1'b1;
      risk_tot_r <= risk_add[RTOT_W] ? RTOT_MAX : risk_add[RTOT_W-1:0];
      sq_tot_r   <= sq_sum[SQTOT_W] ? SQTOT_MAX : sq_sum[SQTOT_W-1:0];
      rcp_tot_r  <= rcp_sum[RCTOT_W] ? RCTOT_MAX : rcp_sum[RCTOT_W-1:0];
      if ($signed(smp_dist_r) < $signed(low_r))
        low_r <= smp_dist_r;
    end
  end

  // Hold the accepted sample
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      smp_risk_r <= in_risk;
      smp_dist_r <= in_dist;
      smp_last_r <= in_tlast;
    end
  end

  // Capture the finishing results as each serial operation completes
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_FIN: begin
        res_ok_r <= all_valid_r && count_r != '0;
        score_r  <= '0;
      end
      ST_MEAN:  if (div_done) mean_r  <= (|div_q[DVD_W-1:16]) ? 16'hFFFF : div_q[15:0];
      ST_CLEAR: if (div_done) clear_r <= (|div_q[DVD_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
      ST_NQ:    if (mul_done) nq_r <= mul_prod[63:0];
      ST_S2:    if (mul_done) s2_r <= mul_prod[63:0];
      ST_VAR:   if (div_done) var_r <= (|div_q[DVD_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
      ST_EA:    if (mul_done) e_r <= mul_prod[E_W-1:0];
      ST_EB:    if (mul_done) e_r <= e_sum;
      ST_LOG: begin
        if (div_done) begin
          n_r   <= div_q[5:0];
          r_r   <= div_rem[31:0];
          pos_r <= ACC_W'(33'h1_0000_0000);
          neg_r <= '0;
          k_r   <= 4'd1;
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          if (k_r[0]) neg_r <= neg_r + ACC_W'(term);
          else        pos_r <= pos_r + ACC_W'(term);
          k_r <= k_r + 1'b1;
        end
      end
      ST_SCORE: score_r <= score_val;
      default: begin
      end
    endcase
  end

  // Output register: load a result when the slot is free, drop valid on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && slot_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && slot_free) begin
      out_tuser_r <= res_ok_r;
      out_tdata_r <= res_ok_r ? {7'd0, score_r, low_r, var_r, clear_r, mean_r} : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### rtl/prs_divider.sv
// Restoring divider, one quotient bit per cycle, for the path reliability scorer.
// Depends on prs_pkg. Runs req.steps steps over the low bits of the dividend.
module prs_divider import prs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  prs_div_req_t     req,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DSR_W-1:0] remainder
);

  logic [DSTP_W-1:0] cnt_r;
  logic              done_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DSR_W:0]    trial;
  logic              fits;

  // Bring down the next dividend bit and test it against the divisor
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= req.steps;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == DSTP_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Shift registers for dividend, quotient and partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend << (DSTP_W'(DVD_W) - req.steps);
      quo_r <= '0;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/prs_multiplier.sv
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on prs_pkg. Runs req.steps steps over the low multiplier bits.
module prs_multiplier import prs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  prs_mul_req_t      req,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic [MSTP_W-1:0] cnt_r;
  logic              done_r;
  logic [MPL_W-1:0]  mpl_r;
  logic [MCD_W-1:0]  mcd_r;
  logic [PROD_W-1:0] prod_r;

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= req.steps;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == MSTP_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Double the partial product and add the multiplicand on a set bit
  always_ff @(posedge clk) begin
    if (req.start) begin
      mpl_r  <= req.mplier << (MSTP_W'(MPL_W) - req.steps);
      mcd_r  <= req.mcand;
      prod_r <= '0;
    end else if (cnt_r != '0) begin
      mpl_r  <= {mpl_r[MPL_W-2:0], 1'b0};
      prod_r <= {prod_r[PROD_W-2:0], 1'b0}
                + (mpl_r[MPL_W-1] ? PROD_W'(mcd_r) : '0);
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

### rtl/prs_checker.sv
// Port-level checks for the path reliability scorer, bound to the top level.
// Depends on prs_pkg and on the port names of path_reliability_scorer.
module prs_checker import prs_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         out_tuser
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An invalid path carries all-zero metrics
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid path with nonzero metrics");

  // The score never exceeds one in Q1.16
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[120:104] <= SCORE_ONE)
    else $error("score out of range");

  // The last sample starts the finishing sequence, so no sample follows at once
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("sample taken right after the last one");

endmodule

bind path_reliability_scorer prs_checker u_prs_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for path_reliability_scorer: streams paths of samples under several
// weight settings and idle patterns, and checks each path result against an
// in-bench predictor. Depends on prs_pkg and the RTL top only.
module tb;
  import prs_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [15:0] mean;
    logic [31:0] clear;
    logic [31:0] var_q;
    logic [23:0] minc;
    logic [16:0] score;
  } path_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  path_reliability_scorer u_top (.*);

  // Predictor copy of registers and path totals
  logic [15:0]        w_risk, w_clear, w_var, w_offset;
  logic [12:0]        n_samples;
  logic [63:0]        sum_risk, sum_square, sum_recip;
  logic signed [23:0] lowest;
  logic               path_ok;

  path_result_t results_pending[$];
  int errors;
  int results_seen;
  int paths_sent;
  int samples_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [16:0] neg_exp_q16(input logic [63:0] x);
    logic [63:0] xq, n, r, term, pos, neg, e, v;
    if (x >= (64'd12 << 24)) return '0;
    xq = x << 8;
    n = xq / 64'(LN2_Q32);
    r = xq - n * 64'(LN2_Q32);
    term = 64'd1 << 32;
    pos = term;
    neg = 0;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * r) >> 32) / 64'(k);
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    e = (pos > neg) ? pos - neg : 64'd0;
    v = (n < 64) ? (e >> n) : 64'd0;
    v = (v + 64'h8000) >> 16;
    if (v > 64'd65536) v = 64'd65536;
    return v[16:0];
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] top);
    return (a + b > top) ? top : a + b;
  endfunction

  task automatic clear_path();
    n_samples = 0;
    sum_risk = 0;
    sum_square = 0;
    sum_recip = 0;
    lowest = 24'sh7F_FFFF;
    path_ok = 1'b1;
  endtask

  // Fold one accepted sample into the totals; queue a result on the last one
  task automatic path_accumulate(input logic [15:0] risk, input logic signed [23:0] dist_val,
                                 input logic ok, input logic last);
    logic [63:0] eps, den, nn, mean, clr, nq, s2, vr, e;
    path_result_t res;
    if (!ok) begin
      path_ok = 1'b0;
    end else if (n_samples < PRS_MAX_SAMPLES) begin
      eps = (w_offset == 0) ? 64'(EPS_DFLT) : 64'(w_offset);
      den = ((dist_val > 0) ? 64'(unsigned'(dist_val)) : 64'd0) + eps;
      n_samples++;
      sum_risk = sat_sum(sum_risk, 64'(risk), 64'(RTOT_MAX));
      sum_square = sat_sum(sum_square, 64'(risk) * 64'(risk), 64'(SQTOT_MAX));
      sum_recip = sat_sum(sum_recip, (64'd1 << 28) / den, 64'(RCTOT_MAX));
      if (dist_val < lowest) lowest = dist_val;
    end
    if (!last) return;
    res = '0;
    if (path_ok && n_samples > 0) begin
      nn = 64'(n_samples);
      mean = sum_risk / nn;
      clr = sum_recip / nn;
      nq = nn * sum_square;
      s2 = sum_risk * sum_risk;
      vr = (nq > s2) ? (nq - s2) / (nn * nn) : 64'd0;
      if (mean > 64'hFFFF) mean = 64'hFFFF;
      if (clr > 64'hFFFF_FFFF) clr = 64'hFFFF_FFFF;
      if (vr > 64'hFFFF_FFFF) vr = 64'hFFFF_FFFF;
      e = ((64'(w_risk) * mean) << 8) + 64'(w_clear) * clr + 64'(w_var) * vr;
      res.valid = 1'b1;
      res.mean = mean[15:0];
      res.clear = clr[31:0];
      res.var_q = vr[31:0];
      res.minc = lowest;
      res.score = neg_exp_q16(e);
    end
    results_pending = {results_pending, res};
    clear_path();
  endtask

  // Send one sample; valid stays high into the next sample unless a gap is drawn
  task automatic send_sample(input logic [15:0] risk, input logic [23:0] dist_val,
                             input logic ok, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {dist_val, risk};
    in_tuser <= ok;
    in_tlast <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    path_accumulate(risk, dist_val, ok, last);
    samples_sent++;
    if (last) paths_sent++;
  endtask

  // Hold valid across back-to-back writes; the caller drops it afterwards
  task automatic cfg_write(input prs_reg_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_RISK_WEIGHT:      w_risk = value;
      REG_CLEARANCE_WEIGHT: w_clear = value;
      REG_VARIANCE_WEIGHT:  w_var = value;
      REG_DISTANCE_OFFSET:  w_offset = value;
    endcase
  endtask

  // Drain results and let the last sample settle before touching registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_weights(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] g, input logic [15:0] eps);
    wait_idle();
    cfg_write(REG_RISK_WEIGHT, a);
    cfg_write(REG_CLEARANCE_WEIGHT, b);
    cfg_write(REG_VARIANCE_WEIGHT, g);
    cfg_write(REG_DISTANCE_OFFSET, eps);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_risk();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 255));
      1: return 16'($urandom_range(0, 1023));
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [23:0] pick_distance();
    case ($urandom_range(4))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 200000));
      2: return 24'($urandom_range(4096, 40000));
      3: return -24'($urandom_range(0, 5000));
      default: return 24'($urandom_range(0, 64));
    endcase
  endfunction

  // One path with random content; a few paths carry invalid samples
  task automatic send_path(input int len);
    int bad_pct;
    bad_pct = ($urandom_range(9) == 0) ? 30 : 0;
    for (int i = 0; i < len; i++)
      send_sample(pick_risk(), pick_distance(), $urandom_range(99) >= bad_pct,
                  i == len - 1);
  endtask

  task automatic test_directed();
    send_sample(16'h0000, 24'h00_0000, 1'b1, 1'b1);
    send_sample(16'hFFFF, 24'h7F_FFFF, 1'b1, 1'b1);
    send_sample(16'hFFFF, 24'h80_0000, 1'b1, 1'b0);
    send_sample(16'h0000, 24'h7F_FFFF, 1'b1, 1'b1);
    send_sample(16'h0100, 24'h00_1000, 1'b1, 1'b0);
    send_sample(16'h0200, 24'hFF_F000, 1'b1, 1'b1);
    // invalid sample in the middle of a path
    send_sample(16'h0100, 24'h00_1000, 1'b1, 1'b0);
    send_sample(16'h0100, 24'h00_1000, 1'b0, 1'b0);
    send_sample(16'h0100, 24'h00_1000, 1'b1, 1'b1);
    // invalid last sample, then a path of one invalid sample only
    send_sample(16'h0080, 24'h00_2000, 1'b1, 1'b0);
    send_sample(16'h0080, 24'h00_2000, 1'b0, 1'b1);
    send_sample(16'hFFFF, 24'h80_0000, 1'b0, 1'b1);
    // high score: tiny risk and far clearance
    send_sample(16'h0001, 24'h7F_0000, 1'b1, 1'b0);
    send_sample(16'h0003, 24'h7F_FFFF, 1'b1, 1'b1);
  endtask

  task automatic test_config_extremes();
    set_weights(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 24'h00_0000, 1'b1, 1'b0);
    send_sample(16'h0000, 24'h80_0000, 1'b1, 1'b1);
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0001, 24'h7F_FFFF, 1'b1, 1'b1);
    send_sample(16'h0000, 24'h00_0000, 1'b1, 1'b1);
    set_weights(16'h0010, 16'h0001, 16'h0001, 16'h0001);
    send_sample(16'h0100, 24'h00_0000, 1'b1, 1'b0);
    send_sample(16'h0300, 24'h01_0000, 1'b1, 1'b1);
  endtask

  // A path longer than the sample limit: the overflow is dropped from the totals
  task automatic test_sample_limit();
    set_weights(16'd256, 16'd1, 16'd1, 16'd4096);
    for (int i = 0; i < PRS_MAX_SAMPLES + 4; i++)
      send_sample(i < PRS_MAX_SAMPLES ? 16'($urandom_range(0, 512)) : 16'hFFFF,
                  i < PRS_MAX_SAMPLES ? 24'($urandom_range(0, 90000)) : 24'h80_0000,
                  1'b1, i == PRS_MAX_SAMPLES + 3);
  endtask

  task automatic test_random(input int n_items, input int idle, input int stall);
    int target;
    wait_idle();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    target = samples_sent + n_items;
    while (samples_sent < target)
      send_path(($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6));
  endtask

  // Result side: random stalls, compare each transfer with the oldest prediction
  always @(posedge clk) begin
    path_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (results_pending.size() == 0) begin
          report_mismatch("unexpected result", 64'd1, 64'd0);
        end else begin
          want = results_pending.pop_front();
          if (out_tuser !== want.valid) report_mismatch("path_valid", out_tuser, want.valid);
          if (out_tdata[15:0] !== want.mean)
            report_mismatch("mean_risk", out_tdata[15:0], want.mean);
          if (out_tdata[47:16] !== want.clear)
            report_mismatch("mean_clearance_risk", out_tdata[47:16], want.clear);
          if (out_tdata[79:48] !== want.var_q)
            report_mismatch("variance", out_tdata[79:48], want.var_q);
          if (out_tdata[103:80] !== want.minc)
            report_mismatch("min_clearance", out_tdata[103:80], want.minc);
          // score may differ by one LSB
          if ($isunknown(out_tdata[120:104]) ||
              out_tdata[120:104] > want.score + 17'd1 ||
              out_tdata[120:104] + 17'd1 < want.score)
            report_mismatch("reliability_score", out_tdata[120:104], want.score);
          if (out_tdata[127:121] !== '0) report_mismatch("padding", out_tdata[127:121], 0);
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 50000) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    in_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_RISK_WEIGHT;
    cfg_data <= '0;
    errors = 0;
    results_seen = 0;
    paths_sent = 0;
    samples_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    w_risk = 16'd256;
    w_clear = 16'd256;
    w_var = 16'd256;
    w_offset = 16'd4;
    clear_path();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_sample_limit();
    set_weights(16'd256, 16'd256, 16'd256, 16'd4);
    test_random(460, 0, 0);
    set_weights(16'd64, 16'd16, 16'd2, 16'd4096);
    test_random(460, 59, 0);
    set_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
    test_random(460, 0, 59);
    set_weights(16'd128, 16'd4, 16'd1, 16'd1);
    test_random(470, 16, 16);

    wait_idle();
    $display("tb: %0d samples in %0d paths, %0d results checked", samples_sent, paths_sent,
             results_seen);
    $display("tb: covered extreme fields and weights, invalid paths, sample limit, stalls");
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
